// ===== rtl/asqs_pkg.sv =====
// ----------------------------------------------------------------------------
// asqs_pkg: shared types and constants
// Field widths, storage sizes, opcodes, status codes, controller states and
// the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package asqs_pkg;

   // storage sizes
   localparam int MAX_ELEMENTS      = 1024;
   localparam int RANGE_STACK_DEPTH = 11;

   // fixed field widths
   localparam int OPCODE_W = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 10;
   localparam int COUNT_W  = 11;
   localparam int STATUS_W = 2;

   // derived widths
   localparam int ADDR_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DEPTH_W = $clog2(RANGE_STACK_DEPTH + 1);
   localparam int PTR_W   = $clog2(RANGE_STACK_DEPTH);

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_WRITE  = 2'd1,
      OP_READ   = 2'd2,
      OP_SORT   = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_BOUNDS = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_PART,
      ST_PIVOT,
      ST_SCAN_I,
      ST_SCAN_J,
      ST_SWAP,
      ST_SPLIT,
      ST_POP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic read_rsp;
      logic part;
      logic pivot;
      logic scan_i;
      logic scan_j;
      logic swap;
      logic split;
      logic pop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic read_ok;
      logic sort_go;
      logic lo_lt_hi;
      logic i_more;
      logic j_more;
      logic i_le_j;
      logic swap_more;
      logic has_child;
      logic depth_zero;
   } stat_type;

endpackage

// ===== rtl/asqs_if.sv =====
// ----------------------------------------------------------------------------
// asqs channel interfaces
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface asqs_req_if
   import asqs_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [OPCODE_W-1:0]       opcode;
   logic signed [VALUE_W-1:0] value;
   logic [POS_W-1:0]          index;
   logic [POS_W-1:0]          range_left;
   logic [POS_W-1:0]          range_right;

   modport source (output valid, opcode, value, index, range_left, range_right,
                   input ready);
   modport sink   (input valid, opcode, value, index, range_left, range_right,
                   output ready);
endinterface

interface asqs_rsp_if
   import asqs_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] read_value;
   logic [COUNT_W-1:0]        element_count;
   logic [STATUS_W-1:0]       status;

   modport source (output valid, read_value, element_count, status, input ready);
   modport sink   (input valid, read_value, element_count, status, output ready);
endinterface

// ===== rtl/array_store_with_quicksort_top.sv =====
// ----------------------------------------------------------------------------
// array_store_with_quicksort_top: element store with in-place sort
// Append, write and read a signed element store; sort a range with a
// middle-pivot Hoare quicksort driven by a bounded range stack.
// ----------------------------------------------------------------------------
// append and write respond in the cycle after transfer; a read passes the memory
// output register, then the response register; sort: each scan step, the two stop
// compares and swap of a swap round, part, pivot, split and pop are each a state;
// one item in flight at a time; next item taken once the response register frees
// reset clears the element count, controller state and response flag;
// element memory is not cleared and needs no clearing pass
module array_store_with_quicksort_top
   import asqs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   asqs_req_if.sink   req_chan,
   asqs_rsp_if.source rsp_chan
);

   cmd_type  cmd;
   stat_type stat;

   asqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   asqs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_chan.opcode),
      .req_value         (req_chan.value),
      .req_index         (req_chan.index),
      .req_range_left    (req_chan.range_left),
      .req_range_right   (req_chan.range_right),
      .rsp_read_value    (rsp_chan.read_value),
      .rsp_element_count (rsp_chan.element_count),
      .rsp_status        (rsp_chan.status)
   );

endmodule

// ===== rtl/asqs_datapath.sv =====
// ----------------------------------------------------------------------------
// asqs_datapath: element memory, sort registers and range stack
// Executes controller commands; one memory read and at most one write per cycle.
// ----------------------------------------------------------------------------
module asqs_datapath
   import asqs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic [OPCODE_W-1:0]       req_opcode,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]          req_index,
   input  logic [POS_W-1:0]          req_range_left,
   input  logic [POS_W-1:0]          req_range_right,
   output logic signed [VALUE_W-1:0] rsp_read_value,
   output logic [COUNT_W-1:0]        rsp_element_count,
   output logic [STATUS_W-1:0]       rsp_status
);

   logic signed [VALUE_W-1:0] mem [MAX_ELEMENTS];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [VALUE_W-1:0] pivot_ff;
   logic signed [VALUE_W-1:0] vi_ff;
   logic [POS_W-1:0]          stk_lo_ff [RANGE_STACK_DEPTH];
   logic [POS_W-1:0]          stk_hi_ff [RANGE_STACK_DEPTH];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [DEPTH_W-1:0]        depth_ff, depth_in;
   logic [POS_W-1:0]          lo_ff, hi_ff, j_ff;
   logic [POS_W:0]            i_ff;
   logic signed [VALUE_W-1:0] read_value_ff;
   logic [COUNT_W-1:0]        count_out_ff;
   status_type                status_ff;

   opcode_type                op;
   status_type                imm_status;
   logic                      idx_ok, left_ok, right_ok, full;
   logic                      has_left, has_right, push_ok;
   logic [POS_W:0]            i_nx, mid_sum;
   logic [POS_W-1:0]          j_nx, left_size, right_size;
   logic [PTR_W-1:0]          top_ptr;
   logic                      we;
   logic [ADDR_W-1:0]         wa, ra;
   logic signed [VALUE_W-1:0] wd;

   // request decode and bounds checks
   always_comb begin
      op       = opcode_type'(req_opcode);
      idx_ok   = CMP_W'(req_index) < CMP_W'(count_ff);
      left_ok  = CMP_W'(req_range_left) < CMP_W'(count_ff);
      right_ok = CMP_W'(req_range_right) < CMP_W'(count_ff);
      full     = count_ff >= CNT_W'(MAX_ELEMENTS);
      case (op)
         OP_APPEND: imm_status = full ? STAT_FULL : STAT_OK;
         OP_WRITE:  imm_status = idx_ok ? STAT_OK : STAT_BOUNDS;
         OP_READ:   imm_status = idx_ok ? STAT_OK : STAT_BOUNDS;
         OP_SORT:   imm_status = (left_ok && right_ok) ? STAT_OK : STAT_BOUNDS;
         default:   imm_status = STAT_OK;
      endcase
      count_in = count_ff;
      if (op == OP_APPEND && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // partition arithmetic
   always_comb begin
      i_nx    = i_ff + (POS_W+1)'(1);
      j_nx    = (j_ff == '0) ? lo_ff : j_ff - POS_W'(1);
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      has_left   = (j_ff > lo_ff) && (i_ff > {1'b0, j_ff});
      has_right  = i_ff < {1'b0, hi_ff};
      left_size  = j_ff - lo_ff;
      right_size = hi_ff - i_ff[POS_W-1:0];
      push_ok    = depth_ff < DEPTH_W'(RANGE_STACK_DEPTH);
      top_ptr    = PTR_W'(depth_ff - DEPTH_W'(1));
   end

   // next stack depth
   always_comb begin
      depth_in = depth_ff;
      if (cmd.accept) begin
         depth_in = '0;
      end else if (cmd.split && has_left && has_right && push_ok) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (cmd.pop && !stat.depth_zero) begin
         depth_in = depth_ff - DEPTH_W'(1);
      end
   end

   // status toward the controller
   always_comb begin
      stat.read_ok    = (op == OP_READ) && idx_ok;
      stat.sort_go    = (op == OP_SORT) && left_ok && right_ok &&
                        (req_range_left < req_range_right);
      stat.lo_lt_hi   = lo_ff < hi_ff;
      stat.i_more     = (i_ff < {1'b0, hi_ff}) && (rdata_ff < pivot_ff);
      stat.j_more     = (j_ff > lo_ff) && (rdata_ff > pivot_ff);
      stat.i_le_j     = i_ff <= {1'b0, j_ff};
      stat.swap_more  = (j_ff != '0) && (i_nx <= {1'b0, j_nx});
      stat.has_child  = has_left || has_right;
      stat.depth_zero = depth_ff == '0;
   end

   // memory port addresses and write data
   always_comb begin
      ra = ADDR_W'(req_index);
      if (cmd.part) begin
         ra = ADDR_W'(mid_sum[POS_W:1]);
      end else if (cmd.pivot) begin
         ra = ADDR_W'(lo_ff);
      end else if (cmd.scan_i) begin
         ra = stat.i_more ? ADDR_W'(i_nx) : ADDR_W'(j_ff);
      end else if (cmd.scan_j) begin
         ra = ADDR_W'(j_ff - POS_W'(1));
      end else if (cmd.swap) begin
         ra = ADDR_W'(i_nx);
      end
      we = 1'b0;
      wa = ADDR_W'(count_ff);
      wd = req_value;
      if (cmd.accept && op == OP_APPEND && !full) begin
         we = 1'b1;
      end else if (cmd.accept && op == OP_WRITE && idx_ok) begin
         we = 1'b1;
         wa = ADDR_W'(req_index);
      end else if (cmd.scan_j && !stat.j_more && stat.i_le_j) begin
         we = 1'b1;
         wa = ADDR_W'(i_ff);
         wd = rdata_ff;
      end else if (cmd.swap) begin
         we = 1'b1;
         wa = ADDR_W'(j_ff);
         wd = vi_ff;
      end
   end

   // element memory
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[ra];
   end

   // count and stack depth
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         depth_ff <= '0;
      end else begin
         if (cmd.accept) begin
            count_ff <= count_in;
         end
         depth_ff <= depth_in;
      end
   end

   // range stack
   always_ff @(posedge clock) begin
      if (cmd.split && has_left && has_right && push_ok) begin
         if (left_size > right_size) begin
            stk_lo_ff[PTR_W'(depth_ff)] <= lo_ff;
            stk_hi_ff[PTR_W'(depth_ff)] <= j_ff;
         end else begin
            stk_lo_ff[PTR_W'(depth_ff)] <= i_ff[POS_W-1:0];
            stk_hi_ff[PTR_W'(depth_ff)] <= hi_ff;
         end
      end
   end

   // partition registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         lo_ff <= req_range_left;
         hi_ff <= req_range_right;
      end
      if (cmd.pivot) begin
         pivot_ff <= rdata_ff;
         i_ff     <= {1'b0, lo_ff};
         j_ff     <= hi_ff;
      end
      if (cmd.scan_i) begin
         if (stat.i_more) begin
            i_ff <= i_nx;
         end else begin
            vi_ff <= rdata_ff;
         end
      end
      if (cmd.scan_j && stat.j_more) begin
         j_ff <= j_ff - POS_W'(1);
      end
      if (cmd.swap) begin
         i_ff <= i_nx;
         j_ff <= j_nx;
      end
      if (cmd.split) begin
         if (has_left && has_right) begin
            if (left_size > right_size) begin
               lo_ff <= i_ff[POS_W-1:0];
            end else begin
               hi_ff <= j_ff;
            end
         end else if (has_left) begin
            hi_ff <= j_ff;
         end else if (has_right) begin
            lo_ff <= i_ff[POS_W-1:0];
         end
      end
      if (cmd.pop && !stat.depth_zero) begin
         lo_ff <= stk_lo_ff[top_ptr];
         hi_ff <= stk_hi_ff[top_ptr];
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         read_value_ff <= '0;
         count_out_ff  <= COUNT_W'(count_in);
         status_ff     <= imm_status;
      end else if (cmd.read_rsp) begin
         read_value_ff <= rdata_ff;
         status_ff     <= STAT_OK;
      end else if (cmd.pop && stat.depth_zero) begin
         read_value_ff <= '0;
         status_ff     <= STAT_OK;
      end
   end

   assign rsp_read_value    = read_value_ff;
   assign rsp_element_count = count_out_ff;
   assign rsp_status        = status_ff;

   // checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ELEMENTS))
      else $error("element count above capacity");
   a_depth_max: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_W'(RANGE_STACK_DEPTH))
      else $error("range stack overflow");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_i |-> i_ff <= {1'b0, hi_ff})
      else $error("left scan beyond range");

endmodule

// ===== rtl/asqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// asqs_ctrl: sequencing state machine
// Accepts one item at a time and walks the partition loop of a sort.
// ----------------------------------------------------------------------------
module asqs_ctrl
   import asqs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, rsp_load;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && stat.read_ok) begin
               state_in = ST_READ;
            end else if (accept && stat.sort_go) begin
               state_in = ST_PART;
            end
         end
         ST_READ:   state_in = ST_IDLE;
         ST_PART:   state_in = stat.lo_lt_hi ? ST_PIVOT : ST_POP;
         ST_PIVOT:  state_in = ST_SCAN_I;
         ST_SCAN_I: state_in = stat.i_more ? ST_SCAN_I : ST_SCAN_J;
         ST_SCAN_J: begin
            if (stat.j_more) begin
               state_in = ST_SCAN_J;
            end else if (stat.i_le_j) begin
               state_in = ST_SWAP;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_SWAP:   state_in = stat.swap_more ? ST_SCAN_I : ST_SPLIT;
         ST_SPLIT:  state_in = stat.has_child ? ST_PART : ST_POP;
         ST_POP:    state_in = stat.depth_zero ? ST_IDLE : ST_PART;
         default:   state_in = ST_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd          = '0;
      cmd.accept   = accept;
      cmd.read_rsp = state_ff == ST_READ;
      cmd.part     = state_ff == ST_PART;
      cmd.pivot    = state_ff == ST_PIVOT;
      cmd.scan_i   = state_ff == ST_SCAN_I;
      cmd.scan_j   = state_ff == ST_SCAN_J;
      cmd.swap     = state_ff == ST_SWAP;
      cmd.split    = state_ff == ST_SPLIT;
      cmd.pop      = state_ff == ST_POP;
      rsp_load     = (accept && !stat.read_ok && !stat.sort_go) ||
                     (state_ff == ST_READ) ||
                     (state_ff == ST_POP && stat.depth_zero);
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and response flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   a_read_path: assert property (@(posedge clock) disable iff (reset)
      (accept && stat.read_ok) |=> state_ff == ST_READ)
      else $error("read did not enter read state");
   a_sort_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP && stat.depth_zero) |=> rsp_valid_ff)
      else $error("sort finished without response");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("response dropped while stalled");

endmodule

// ===== tb/array_store_with_quicksort_tb_if.sv =====
// ----------------------------------------------------------------------------
// array_store_with_quicksort_tb_if: testbench side of the channels
// The block's own channel interfaces from the RTL are used unchanged; this
// file only supplies the request and response types the testbench shares.
// ----------------------------------------------------------------------------
package asqs_tb_pkg;
   import asqs_pkg::*;

   // one request as the testbench keeps it
   typedef struct {
      opcode_type                opcode;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          index;
      logic [POS_W-1:0]          range_left;
      logic [POS_W-1:0]          range_right;
   } request_type;

   // one response as the testbench expects it
   typedef struct {
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_W-1:0]        element_count;
      status_type                status;
   } response_type;

endpackage

// ===== tb/array_store_with_quicksort_top_tb.sv =====
// ----------------------------------------------------------------------------
// array_store_with_quicksort_top_tb: self-checking bench for the sort store
// Drives append, write, read and sort requests with random idling on both
// channels, predicts each response with a behavioral copy of the store and
// its quicksort, and compares every response field by field.
// ----------------------------------------------------------------------------
module array_store_with_quicksort_top_tb;
   import asqs_pkg::*;
   import asqs_tb_pkg::*;

   logic clock;
   logic reset;

   asqs_req_if req_chan ();
   asqs_rsp_if rsp_chan ();

   array_store_with_quicksort_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // predictor state
   logic signed [VALUE_W-1:0] model_store [MAX_ELEMENTS];
   int unsigned               model_count;
   logic [POS_W-1:0]          model_stack_lo [RANGE_STACK_DEPTH];
   logic [POS_W-1:0]          model_stack_hi [RANGE_STACK_DEPTH];

   request_type  pending_requests [$];
   response_type expected_responses [$];

   int  mismatch_count;
   bit  tail_quiet;
   int  hold_off_cycles;
   bit  req_taken;

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // in-place hoare quicksort with middle pivot and bounded range stack
   task automatic quicksort_range(input int unsigned lo_in, input int unsigned hi_in);
      int unsigned lo, hi, i, j, depth;
      logic signed [VALUE_W-1:0] pivot, swap_tmp;
      bit active, crossed, has_left, has_right;
      lo = lo_in;
      hi = hi_in;
      depth = 0;
      active = 1;
      while (active) begin
         if (lo < hi) begin
            i = lo;
            j = hi;
            pivot = model_store[(lo + hi) / 2];
            crossed = 0;
            while (!crossed) begin
               while (i < hi && model_store[i] < pivot) i++;
               while (j > lo && model_store[j] > pivot) j--;
               if (i <= j) begin
                  swap_tmp = model_store[i];
                  model_store[i] = model_store[j];
                  model_store[j] = swap_tmp;
                  i++;
                  if (j == 0) begin
                     crossed = 1;
                     j = lo;
                     break;
                  end
                  j--;
               end
               if (i > j) crossed = 1;
            end
            has_left  = (j > lo) && (i > j);
            has_right = i < hi;
            if (has_left && has_right) begin
               if ((j - lo) > (hi - i)) begin
                  if (depth < RANGE_STACK_DEPTH) begin
                     model_stack_lo[depth] = lo;
                     model_stack_hi[depth] = j;
                     depth++;
                  end
                  lo = i;
               end else begin
                  if (depth < RANGE_STACK_DEPTH) begin
                     model_stack_lo[depth] = i;
                     model_stack_hi[depth] = hi;
                     depth++;
                  end
                  hi = j;
               end
               continue;
            end else if (has_left) begin
               hi = j;
               continue;
            end else if (has_right) begin
               lo = i;
               continue;
            end
         end
         if (depth == 0) begin
            active = 0;
         end else begin
            depth--;
            lo = model_stack_lo[depth];
            hi = model_stack_hi[depth];
         end
      end
   endtask

   // predict the response of one accepted request
   task automatic predict_response(input request_type rq);
      response_type rs;
      rs.read_value = '0;
      rs.status = STAT_OK;
      case (rq.opcode)
         OP_APPEND: begin
            if (model_count >= MAX_ELEMENTS) begin
               rs.status = STAT_FULL;
            end else begin
               model_store[model_count] = rq.value;
               model_count++;
            end
         end
         OP_WRITE: begin
            if (rq.index >= model_count) rs.status = STAT_BOUNDS;
            else model_store[rq.index] = rq.value;
         end
         OP_READ: begin
            if (rq.index >= model_count) rs.status = STAT_BOUNDS;
            else rs.read_value = model_store[rq.index];
         end
         default: begin
            if (rq.range_left >= model_count || rq.range_right >= model_count)
               rs.status = STAT_BOUNDS;
            else if (rq.range_left < rq.range_right)
               quicksort_range(rq.range_left, rq.range_right);
         end
      endcase
      rs.element_count = model_count[COUNT_W-1:0];
      expected_responses.push_back(rs);
   endtask

   // request builders
   function automatic request_type make_request(opcode_type op, logic [31:0] val,
                                                int unsigned idx, int unsigned lft,
                                                int unsigned rgt);
      request_type rq;
      rq.opcode = op;
      rq.value = val;
      rq.index = idx[POS_W-1:0];
      rq.range_left = lft[POS_W-1:0];
      rq.range_right = rgt[POS_W-1:0];
      return rq;
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7) - 3;
         3: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // sender: driven at the falling edge, next item once the last one transferred
   int send_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            request_type rq;
            rq = pending_requests[0];
            req_chan.valid       <= 1'b1;
            req_chan.opcode      <= rq.opcode;
            req_chan.value       <= rq.value;
            req_chan.index       <= rq.index;
            req_chan.range_left  <= rq.range_left;
            req_chan.range_right <= rq.range_right;
            if (!tail_quiet && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 4);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // request transfers feed the predictor
   always @(posedge clock) begin
      req_taken = !reset && req_chan.valid && req_chan.ready;
      if (req_taken) begin
         predict_response(pending_requests.pop_front());
      end
   end

   // receiver ready with random bursts of stall and one long hold-off
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!tail_quiet && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 4);
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: value %0d count %0d status %0d",
                        rsp_chan.read_value, rsp_chan.element_count, rsp_chan.status);
         end else begin
            response_type ex;
            ex = expected_responses.pop_front();
            if (rsp_chan.read_value !== ex.read_value ||
                rsp_chan.element_count !== ex.element_count ||
                rsp_chan.status !== ex.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value %0d count %0d status %0d, got %0d %0d %0d",
                           ex.read_value, ex.element_count, ex.status,
                           rsp_chan.read_value, rsp_chan.element_count, rsp_chan.status);
            end
         end
      end
   end

   // wait until the sender queue is empty and every response is back
   task automatic drain_all();
      while (pending_requests.size() > 0 || expected_responses.size() > 0)
         @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned cnt, lft, rgt, n, k;
      int r;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_APPEND;
      req_chan.value = '0;
      req_chan.index = '0;
      req_chan.range_left = '0;
      req_chan.range_right = '0;
      rsp_chan.ready = 1'b0;
      mismatch_count = 0;
      tail_quiet = 0;
      hold_off_cycles = 0;
      model_count = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: operations on an empty store, extremes, special cases
      pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_WRITE, 5, 0, 0, 0));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_APPEND, 32'h7fff_ffff, 0, 0, 0));
      pending_requests.push_back(make_request(OP_APPEND, 32'h8000_0000, 1023, 1023, 1023));
      pending_requests.push_back(make_request(OP_APPEND, 32'hffff_ffff, 0, 0, 0));
      pending_requests.push_back(make_request(OP_APPEND, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_APPEND, 32'h5555_aaaa, 0, 0, 0));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 0, 4));
      pending_requests.push_back(make_request(OP_READ, 0, 0, 0, 0));
      pending_requests.push_back(make_request(OP_READ, 0, 4, 0, 0));
      pending_requests.push_back(make_request(OP_READ, 0, 5, 0, 0));
      pending_requests.push_back(make_request(OP_READ, 0, 1023, 0, 0));
      pending_requests.push_back(make_request(OP_WRITE, 32'haaaa_5555, 2, 0, 0));
      pending_requests.push_back(make_request(OP_WRITE, 1, 1023, 0, 0));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 3, 1));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 2, 2));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 0, 5));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 1023, 0));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 4, 0));
      pending_requests.push_back(make_request(OP_READ, 0, 2, 0, 0));

      // long receiver hold-off while requests keep coming
      for (k = 0; k < 12; k++)
         pending_requests.push_back(make_request(OP_READ, 0, k % 6, 0, 0));
      @(negedge clock);
      hold_off_cycles = 300;
      drain_all();

      // sender pause until all responses returned, then random traffic
      cnt = 5;
      for (n = 0; n < 500; n++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            pending_requests.push_back(make_request(OP_APPEND, random_value(), $urandom,
                                                    $urandom, $urandom));
            if (cnt < MAX_ELEMENTS) cnt++;
         end else if (r < 48) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, cnt);
            pending_requests.push_back(make_request(OP_WRITE, random_value(), k,
                                                    $urandom, $urandom));
         end else if (r < 80) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, cnt);
            pending_requests.push_back(make_request(OP_READ, $urandom, k,
                                                    $urandom, $urandom));
         end else begin
            // mostly small in-bounds ranges to keep sort time modest
            lft = $urandom_range(0, cnt - 1);
            rgt = lft + $urandom_range(0, 24);
            if ($urandom_range(0, 9) == 0) begin
               lft = $urandom_range(0, 1023);
               rgt = $urandom_range(0, 1023);
            end else if ($urandom_range(0, 9) == 0) begin
               rgt = $urandom_range(0, lft);
            end
            if (rgt > 1023) rgt = 1023;
            pending_requests.push_back(make_request(OP_SORT, $urandom, $urandom, lft, rgt));
         end
      end
      drain_all();

      // fill the store, sort it whole, hit the full case and read back
      while (cnt < MAX_ELEMENTS) begin
         pending_requests.push_back(make_request(OP_APPEND, random_value(), 0, 0, 0));
         cnt++;
      end
      pending_requests.push_back(make_request(OP_APPEND, 32'h1234_5678, 0, 0, 0));
      pending_requests.push_back(make_request(OP_SORT, 0, 0, 0, 1023));
      tail_quiet = 1;
      for (k = 0; k < 40; k++)
         pending_requests.push_back(make_request(OP_READ, 0, $urandom_range(0, 1023), 0, 0));
      pending_requests.push_back(make_request(OP_READ, 0, 1023, 0, 0));
      drain_all();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/asqs_pkg.sv
rtl/asqs_if.sv
rtl/asqs_datapath.sv
rtl/asqs_ctrl.sv
rtl/array_store_with_quicksort_top.sv
tb/array_store_with_quicksort_tb_if.sv
tb/array_store_with_quicksort_top_tb.sv
